>>> src/ccar_pkg.sv
// Shared types, constants and helpers for the capability check and audit ring.
`timescale 1ns / 1ps
package ccar_pkg;

   // Defaults for the top-level parameters
   localparam int LOG_DEPTH_DEF = 128;
   localparam int CAP_WIDTH_DEF = 32;

   // Fixed field widths of the request and response beats
   localparam int ID_W      = 32;
   localparam int CAPS_W    = 32;
   localparam int KIND_W    = 4;
   localparam int INDEX_W   = 7;
   localparam int SEQ_W     = 64;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // Subject logged when a check carries no context
   localparam logic [ID_W-1:0] NONE_SUBJECT = 32'hffff_ffff;

   // Kinds below this limit own one capability bit each
   localparam logic [KIND_W-1:0] KIND_OWN_LIMIT = 4'd8;

   // Action codes
   localparam logic ACT_CHECK = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENFORCING     = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDATA
   } state_type;

   typedef struct packed {
      logic               action;
      logic               has_context;
      logic [ID_W-1:0]    requester_id;
      logic [CAPS_W-1:0]  present_caps;
      logic [KIND_W-1:0]  request_kind;
      logic [ID_W-1:0]    target_id;
      logic [CAPS_W-1:0]  extra_required_caps;
      logic [INDEX_W-1:0] audit_index;
   } req_type;

   typedef struct packed {
      logic               allowed;
      logic               read_ok;
      logic [SEQ_W-1:0]   entry_sequence;
      logic [ID_W-1:0]    entry_subject;
      logic [KIND_W-1:0]  entry_kind;
      logic [ID_W-1:0]    entry_object;
      logic               entry_allowed;
      logic [CAPS_W-1:0]  entry_required;
      logic [CAPS_W-1:0]  entry_present;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // Control from the sequencer to the ring bookkeeping
   typedef struct packed {
      logic               commit;
      logic [INDEX_W-1:0] audit_index;
   } ring_ctrl_type;

   // Own capability bit of a request kind, in the widest mask form
   function automatic logic [63:0] kind_cap(input logic [KIND_W-1:0] kind);
      logic [63:0] mask;
      mask = '0;
      if (kind < KIND_OWN_LIMIT) begin
         mask[kind[2:0]] = 1'b1;
      end
      return mask;
   endfunction

endpackage

>>> src/capability_check_with_audit_ring.sv
// Top level: capability check with decision logging into an audit ring.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+------------------------------
//   request | start, busy, req_data                  | beat taken when start & !busy
//   result  | rsp_strobe, rsp_data                   | one-cycle strobe, no back-pressure
//   csr     | csr_valid, csr_ready, csr_index/_data  | write when csr_valid & csr_ready
//
// A check is accepted, then decided and its log entry written; a read is accepted,
// then addresses the log RAM, then captures its registered read data; an out-of-range
// read is accepted, then answered from the fill count with no log RAM access.
// The result appears in the cycle after the item finishes and a new item may be
// accepted in that same cycle. Reset (synchronous) clears pointer, count, sequence
// and restores both control registers to 1; log contents are not cleared.
// The result side cannot stall, so busy depends only on the item in flight.
`timescale 1ns / 1ps
module capability_check_with_audit_ring #(
   parameter int LOG_DEPTH = ccar_pkg::LOG_DEPTH_DEF,
   parameter int CAP_WIDTH = ccar_pkg::CAP_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  ccar_pkg::req_type                  req_data,
   output logic                               rsp_strobe,
   output ccar_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ccar_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ccar_pkg::CSR_DAT_W-1:0]     csr_data
);
   import ccar_pkg::*;

   localparam int PTR_W  = $clog2(LOG_DEPTH);
   localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
   // Log word: {sequence, subject, object, required, present, decision, kind}
   localparam int KIND_LO = 0;
   localparam int DEC_LO  = KIND_LO + KIND_W;
   localparam int PRES_LO = DEC_LO + 1;
   localparam int REQ_LO  = PRES_LO + CAP_WIDTH;
   localparam int OBJ_LO  = REQ_LO + CAP_WIDTH;
   localparam int SUBJ_LO = OBJ_LO + ID_W;
   localparam int SEQ_LO  = SUBJ_LO + ID_W;
   localparam int WORD_W  = SEQ_LO + SEQ_W;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_strobe_ff, rsp_strobe_in;
   logic      enabled_ff, enforcing_ff;

   ring_ctrl_type    ring_ctrl;
   logic [PTR_W-1:0] wr_ptr, rd_ptr;
   logic [CNT_W-1:0] count, count_next;
   logic [SEQ_W-1:0] seq_next;
   logic             hit;

   logic              ram_wr_en, ram_rd_en;
   logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

   logic                 load_check, load_miss, load_hit;
   logic [63:0]          pres_wide, reqd_wide, rd_pres_wide, rd_reqd_wide;
   logic [CAP_WIDTH-1:0] pres_cap, reqd_cap;
   logic [ID_W-1:0]      subject;
   logic                 decision;

   // Configuration registers; writes land only while idle
   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b1;
         enforcing_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BLOCK_ENABLED) begin
            enabled_ff <= csr_data[0];
         end
         if (csr_index == CSR_ENFORCING) begin
            enforcing_ff <= csr_data[0];
         end
      end
   end

   // Hold the request beat for the life of the item
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.action == ACT_READ && hit) begin
               state_in = ST_RDATA;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RDATA: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      busy                  = (state_ff != ST_IDLE);
      ring_ctrl.commit      = (state_ff == ST_EXEC) && (req_ff.action == ACT_CHECK);
      ring_ctrl.audit_index = req_ff.audit_index;
      load_check            = ring_ctrl.commit;
      load_miss             = (state_ff == ST_EXEC) && (req_ff.action == ACT_READ) && !hit;
      ram_rd_en             = (state_ff == ST_EXEC) && (req_ff.action == ACT_READ) && hit;
      load_hit              = (state_ff == ST_RDATA);
      ram_wr_en             = ring_ctrl.commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Check: drop caps when there is no context, fold the kind's own bit into required
   always_comb begin
      pres_wide = 64'(req_ff.present_caps);
      reqd_wide = 64'(req_ff.extra_required_caps) | kind_cap(req_ff.request_kind);
      pres_cap  = req_ff.has_context ? pres_wide[CAP_WIDTH-1:0] : '0;
      reqd_cap  = reqd_wide[CAP_WIDTH-1:0];
      subject   = req_ff.has_context ? req_ff.requester_id : NONE_SUBJECT;
      priority if (!enabled_ff) begin
         decision = 1'b0;
      end else if (!enforcing_ff) begin
         decision = 1'b1;
      end else begin
         decision = ((pres_cap & reqd_cap) == reqd_cap);
      end
   end

   assign ram_wr_data = {seq_next, subject, req_ff.target_id, reqd_cap, pres_cap,
                         decision, req_ff.request_kind};

   ccar_ring #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ring_ctrl),
      .wr_ptr     (wr_ptr),
      .rd_ptr     (rd_ptr),
      .count      (count),
      .count_next (count_next),
      .seq_next   (seq_next),
      .hit        (hit)
   );

   // A read always follows the write of its entry by at least one item, so no
   // same-entry overlap can occur and no forwarding path is needed.
   ccar_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr),
      .rd_data (ram_rd_data)
   );

   // Result beat
   always_comb begin
      rd_pres_wide  = 64'(ram_rd_data[PRES_LO +: CAP_WIDTH]);
      rd_reqd_wide  = 64'(ram_rd_data[REQ_LO +: CAP_WIDTH]);
      rsp_in        = '0;
      rsp_strobe_in = load_check || load_miss || load_hit;
      priority if (load_check) begin
         rsp_in.allowed     = decision;
         rsp_in.entry_count = COUNT_W'(count_next);
      end else if (load_miss) begin
         rsp_in.entry_count = COUNT_W'(count);
      end else if (load_hit) begin
         rsp_in.read_ok        = 1'b1;
         rsp_in.entry_sequence = ram_rd_data[SEQ_LO +: SEQ_W];
         rsp_in.entry_subject  = ram_rd_data[SUBJ_LO +: ID_W];
         rsp_in.entry_kind     = ram_rd_data[KIND_LO +: KIND_W];
         rsp_in.entry_object   = ram_rd_data[OBJ_LO +: ID_W];
         rsp_in.entry_allowed  = ram_rd_data[DEC_LO];
         rsp_in.entry_required = rd_reqd_wide[CAPS_W-1:0];
         rsp_in.entry_present  = rd_pres_wide[CAPS_W-1:0];
         rsp_in.entry_count    = COUNT_W'(count);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTH
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_RDATA))
      else $error("result beat without an item finishing");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.allowed && rsp_data.read_ok))
      else $error("result marks both a decision and a read");
`endif

endmodule

>>> src/ccar_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ccar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ccar_ring.sv
// Ring bookkeeping: write pointer, saturating fill count, sequence counter, read slot.
`timescale 1ns / 1ps
module ccar_ring #(
   parameter int LOG_DEPTH = ccar_pkg::LOG_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ccar_pkg::ring_ctrl_type          ctrl,
   output logic [$clog2(LOG_DEPTH)-1:0]     wr_ptr,
   output logic [$clog2(LOG_DEPTH)-1:0]     rd_ptr,
   output logic [$clog2(LOG_DEPTH+1)-1:0]   count,
   output logic [$clog2(LOG_DEPTH+1)-1:0]   count_next,
   output logic [ccar_pkg::SEQ_W-1:0]       seq_next,
   output logic                             hit
);
   import ccar_pkg::*;

   localparam int PTR_W = $clog2(LOG_DEPTH);
   localparam int CNT_W = $clog2(LOG_DEPTH + 1);
   localparam int SUM_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 2;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LOG_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LOG_DEPTH);
   localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(LOG_DEPTH);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [SUM_W-1:0] pos_sum, pos_cnt, pos_slot;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      if (ctrl.commit) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = (count_ff == CNT_FULL) ? count_ff : count_ff + 1'b1;
         seq_in    = seq_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         count_ff  <= '0;
         seq_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         seq_ff    <= seq_in;
      end
   end

   // Slot of the entry audit_index places past the oldest: wr_ptr - count + index, mod depth.
   always_comb begin
      pos_sum = SUM_W'(wr_ptr_ff) + SUM_W'(ctrl.audit_index);
      pos_cnt = SUM_W'(count_ff);
      if (pos_sum >= pos_cnt) begin
         pos_slot = pos_sum - pos_cnt;
      end else begin
         pos_slot = pos_sum + SUM_DEPTH - pos_cnt;
      end
   end

   assign hit        = SUM_W'(ctrl.audit_index) < pos_cnt;
   assign rd_ptr     = pos_slot[PTR_W-1:0];
   assign wr_ptr     = wr_ptr_ff;
   assign count      = count_ff;
   assign count_next = count_in;
   assign seq_next   = seq_ff + 1'b1;

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fill count beyond ring depth");
   a_ptr_bounded: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff <= PTR_LAST)
      else $error("write pointer beyond ring depth");
   a_commit_seq: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> seq_ff == $past(seq_ff) + 1'b1)
      else $error("sequence did not advance on commit");
`endif

endmodule

>>> tb/ccar_audit_scoreboard_pkg.sv
// Scoreboard class that predicts and checks capability decisions and audit log reads.
`timescale 1ns / 1ps
package ccar_audit_scoreboard_pkg;
   import ccar_pkg::*;

   // Kind that asks for a system call and owns no capability bit
   localparam logic [KIND_W-1:0] KIND_SYSCALL = 4'd8;
   localparam int RING_DEPTH = LOG_DEPTH_DEF;

   class audit_scoreboard;
      typedef struct packed {
         logic [SEQ_W-1:0]  seq;
         logic [ID_W-1:0]   subject;
         logic [ID_W-1:0]   object;
         logic [CAPS_W-1:0] required;
         logic [CAPS_W-1:0] present;
         logic [KIND_W-1:0] kind;
         logic              decision;
      } log_entry_type;

      bit                 enabled;
      bit                 enforcing;
      int                 wr_ptr;
      logic [COUNT_W-1:0] count;
      logic [SEQ_W-1:0]   seq;
      log_entry_type      ring[RING_DEPTH];
      rsp_type            expected_q[$];

      int mismatches;
      int results_seen;
      int checks;
      int allows;
      int reads;
      int read_hits;

      function new();
         enabled   = 1'b1;
         enforcing = 1'b1;
         wr_ptr    = 0;
         count     = '0;
         seq       = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, bit value);
         case (idx)
            CSR_BLOCK_ENABLED: enabled = value;
            CSR_ENFORCING:     enforcing = value;
            default: ;
         endcase
      endfunction

      // Work out the decision or the log entry for an accepted request beat.
      function void note_request(req_type r);
         rsp_type           want;
         log_entry_type     e;
         logic [CAPS_W-1:0] own;
         int                slot;
         want = '0;
         if (r.action == ACT_CHECK) begin
            checks++;
            own = '0;
            if (r.request_kind < KIND_OWN_LIMIT) own = 32'h1 << r.request_kind;
            e.subject  = r.has_context ? r.requester_id : NONE_SUBJECT;
            e.present  = r.has_context ? r.present_caps : '0;
            e.required = r.extra_required_caps | own;
            e.kind     = r.request_kind;
            e.object   = r.target_id;
            if (!enabled) e.decision = 1'b0;
            else if (!enforcing) e.decision = 1'b1;
            else e.decision = ((e.present & e.required) == e.required);
            seq   = seq + 1;
            e.seq = seq;
            ring[wr_ptr] = e;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (count < RING_DEPTH) count++;
            want.allowed = e.decision;
            if (e.decision) allows++;
         end else begin
            reads++;
            if (r.audit_index < count) begin
               read_hits++;
               slot = (wr_ptr + RING_DEPTH - int'(count) + int'(r.audit_index)) % RING_DEPTH;
               e = ring[slot];
               want.read_ok        = 1'b1;
               want.entry_sequence = e.seq;
               want.entry_subject  = e.subject;
               want.entry_kind     = e.kind;
               want.entry_object   = e.object;
               want.entry_allowed  = e.decision;
               want.entry_required = e.required;
               want.entry_present  = e.present;
            end
         end
         want.entry_count = count;
         expected_q.push_back(want);
      endfunction

      function string diff(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) return $sformatf(" %s exp=%0h got=%0h", name, want, got);
         return "";
      endfunction

      // Compare one result beat with the oldest outstanding expectation.
      function void check_response(rsp_type got);
         rsp_type want;
         string   bad;
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %0d", results_seen);
            return;
         end
         want = expected_q.pop_front();
         bad = {diff("allowed", want.allowed, got.allowed),
                diff("read_ok", want.read_ok, got.read_ok),
                diff("entry_sequence", want.entry_sequence, got.entry_sequence),
                diff("entry_subject", want.entry_subject, got.entry_subject),
                diff("entry_kind", want.entry_kind, got.entry_kind),
                diff("entry_object", want.entry_object, got.entry_object),
                diff("entry_allowed", want.entry_allowed, got.entry_allowed),
                diff("entry_required", want.entry_required, got.entry_required),
                diff("entry_present", want.entry_present, got.entry_present),
                diff("entry_count", want.entry_count, got.entry_count)};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10) $display("result beat %0d mismatch:%s", results_seen, bad);
         end
      endfunction

      function int failures();
         return mismatches + expected_q.size();
      endfunction
   endclass

endpackage

>>> tb/tb_capability_check_with_audit_ring.sv
// Testbench top: drives checks, log reads and register writes against the audit ring.
`timescale 1ns / 1ps
module tb_capability_check_with_audit_ring;
   import ccar_pkg::*;
   import ccar_audit_scoreboard_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BLOCK_ENABLED;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   audit_scoreboard audit_sb = new();
   int              csr_writes = 0;

   capability_check_with_audit_ring dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Sample both channels at the rising edge. Check the result first: a
   // result leaving in the same cycle as a new accept always belongs to the
   // older item, so the order in the expectation queue holds either way.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) audit_sb.check_response(rsp_data);
         if (start && !busy) audit_sb.note_request(req_data);
      end
   end

   // Hard stop well beyond the slowest legal run (about 1550 beats with
   // long gaps and reads through the log RAM stay far below this).
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Present one request beat at the falling edge after an optional gap and
   // hold it until the block takes it. Return at the falling edge after the
   // accept so the next beat can follow without a bubble.
   task automatic drive_beat(input req_type item, input int gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Write one control register once the block has drained. Upper data bits
   // are random; only bit 0 carries the setting.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input bit value);
      logic [CSR_DAT_W-1:0] word;
      start = 1'b0;
      while (audit_sb.expected_q.size() != 0) @(negedge clock);
      repeat ($urandom_range(0, 4)) @(negedge clock);
      word      = $urandom;
      word[0]   = value;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = word;
      do @(posedge clock); while (!csr_ready);
      audit_sb.set_register(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_type check_beat(input bit ctx, input logic [31:0] subj,
                                          input logic [31:0] caps,
                                          input logic [KIND_W-1:0] kind,
                                          input logic [31:0] obj,
                                          input logic [31:0] extra);
      req_type r;
      r.action              = ACT_CHECK;
      r.has_context         = ctx;
      r.requester_id        = subj;
      r.present_caps        = caps;
      r.request_kind        = kind;
      r.target_id           = obj;
      r.extra_required_caps = extra;
      r.audit_index         = INDEX_W'($urandom);   // ignored on checks
      return r;
   endfunction

   // Read beat: the check fields carry noise that the block must ignore.
   function automatic req_type read_beat(input logic [INDEX_W-1:0] idx);
      req_type r;
      r = check_beat(1'($urandom), $urandom, $urandom, KIND_W'($urandom), $urandom,
                     $urandom);
      r.action      = ACT_READ;
      r.audit_index = idx;
      return r;
   endfunction

   // Random item: mostly checks whose present mask sits near the required
   // one so both decisions show up, and reads aimed mostly at live entries.
   function automatic req_type random_beat(input logic [COUNT_W-1:0] logged);
      logic [31:0]       extra;
      logic [31:0]       required;
      logic [31:0]       caps;
      logic [KIND_W-1:0] kind;
      if ($urandom_range(0, 99) < 40) begin
         if (logged != 0 && $urandom_range(0, 4) != 0)
            return read_beat(INDEX_W'($urandom_range(0, int'(logged) - 1)));
         return read_beat(INDEX_W'($urandom_range(0, 127)));
      end
      kind = KIND_W'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0:       extra = '0;
         1:       extra = $urandom & $urandom & $urandom;
         2:       extra = $urandom;
         default: extra = 32'h1 << $urandom_range(0, 31);
      endcase
      required = extra;
      if (kind < KIND_OWN_LIMIT) required[kind[2:0]] = 1'b1;
      case ($urandom_range(0, 2))
         0:       caps = $urandom;
         1:       caps = required | $urandom;
         default: begin
            caps = required | $urandom;
            caps[5'($urandom_range(0, 31))] = 1'b0;   // likely knock out a needed bit
         end
      endcase
      return check_beat($urandom_range(0, 9) != 0, $urandom, caps, kind, $urandom, extra);
   endfunction

   // Mostly short gaps, a few long ones; zero inside quiet stretches.
   function automatic int pick_gap(input bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      bit en_plan[5]  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      bit enf_plan[5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      bit quiet;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, reset settings: reads of an empty log must fail.
      drive_beat(read_beat(0), 0);
      drive_beat(read_beat(127), 1);
      // Own capability bit at both ends of the owned range, syscall and
      // kinds without a bit, full and empty masks, and checks with no context.
      drive_beat(check_beat(1, 32'h0, 32'hffff_ffff, 4'd0, 32'hffff_ffff, 32'h0), 0);
      drive_beat(check_beat(1, 32'hffff_ffff, 32'h0000_007f, 4'd7, 32'h0, 32'h0), 0);
      drive_beat(check_beat(1, $urandom, 32'h0, KIND_SYSCALL, $urandom, 32'h0), 2);
      drive_beat(check_beat(1, $urandom, 32'h0, 4'd15, $urandom, 32'h0), 0);
      drive_beat(check_beat(1, $urandom, 32'hffff_ffff, 4'd9, $urandom, 32'hffff_ffff), 0);
      drive_beat(check_beat(0, $urandom, $urandom, 4'd3, $urandom, 32'h0), 0);
      drive_beat(check_beat(0, $urandom, 32'hffff_ffff, KIND_SYSCALL, $urandom, 32'h0), 1);
      drive_beat(check_beat(1, $urandom, 32'h7fff_ffff, 4'd12, $urandom, 32'h8000_0000), 0);
      drive_beat(check_beat(1, 32'h0, 32'h0000_0020, 4'd5, 32'hffff_ffff, 32'h0), 0);
      drive_beat(check_beat(1, 32'hffff_ffff, 32'h0000_0010, 4'd5, 32'h0, 32'h0), 0);
      // Read back oldest and newest, then one past the end and the top index.
      drive_beat(read_beat(0), 0);
      drive_beat(read_beat(INDEX_W'(audit_sb.count - 1)), 0);
      drive_beat(read_beat(INDEX_W'(audit_sb.count)), 3);
      drive_beat(read_beat(127), 0);

      // Random part: walk the register settings, extremes included; the
      // checks wrap the ring several times so the full-ring reads get hit.
      quiet = 1'b0;
      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_BLOCK_ENABLED, en_plan[p]);
         write_csr(CSR_ENFORCING, enf_plan[p]);
         for (int i = 0; i < 307; i++) begin
            if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            drive_beat(random_beat(audit_sb.count), pick_gap(quiet));
         end
      end
      start = 1'b0;

      // Drain, then keep sampling so that stray beats can show.
      while (audit_sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d checks (%0d allowed) and %0d log reads (%0d hit live entries)",
               audit_sb.checks, audit_sb.allows, audit_sb.reads, audit_sb.read_hits);
      $display("%0d register writes, %0d results compared, %0d mismatches, %0d missing",
               csr_writes, audit_sb.results_seen, audit_sb.mismatches,
               audit_sb.expected_q.size());
      if (audit_sb.failures() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
